>>> rtl/m3ms_pkg.sv
package m3ms_pkg;

	localparam int SAMPLE_W = 20;
	localparam int SUM_W    = 32;
	localparam int WLEN_W   = 6;
	localparam int TAPS     = 3;

	localparam logic [WLEN_W-1:0] WLEN_RESET = 6'd21;

	// median ring slot codes
	localparam logic [1:0] SLOT_0 = 2'd0;
	localparam logic [1:0] SLOT_1 = 2'd1;
	localparam logic [1:0] SLOT_2 = 2'd2;

	typedef logic [SAMPLE_W-1:0] sample_t;
	typedef logic [SUM_W-1:0]    sum_t;

	// one item after the window memory read, handed to the accumulator
	typedef struct packed {
		logic    valid;
		sample_t filtered;
		sample_t sub;
		logic    ready;
	} stage_t;

	function automatic sample_t med3(input sample_t a, input sample_t b, input sample_t c);
		sample_t lo;
		sample_t hi;
		lo = (a < b) ? a : b;
		hi = (a < b) ? b : a;
		if (c <= lo) begin
			return lo;
		end else if (c >= hi) begin
			return hi;
		end
		return c;
	endfunction

endpackage

>>> rtl/m3ms_median.sv
module m3ms_median (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              acc,
	input  m3ms_pkg::sample_t sample,
	output m3ms_pkg::sample_t filtered
);
	import m3ms_pkg::*;

	sample_t    tap_q [TAPS];
	logic [1:0] slot_q;
	logic       full_q;

	sample_t    tap_new [TAPS];
	logic       full_new;

	// ring contents as they stand after this sample is stored
	always_comb begin
		for (int i = 0; i < TAPS; i++) begin
			tap_new[i] = (slot_q == 2'(i)) ? sample : tap_q[i];
		end
		full_new = full_q || (slot_q == SLOT_2);
		filtered = full_new ? med3(tap_new[0], tap_new[1], tap_new[2]) : sample;
	end

	// ring storage
	always_ff @(posedge clk) begin
		if (acc) begin
			for (int i = 0; i < TAPS; i++) begin
				tap_q[i] <= tap_new[i];
			end
		end
	end

	// ring pointer and fill flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= SLOT_0;
			full_q <= 1'b0;
		end else if (acc) begin
			full_q <= full_new;
			unique case (slot_q)
				SLOT_0:  slot_q <= SLOT_1;
				SLOT_1:  slot_q <= SLOT_2;
				default: slot_q <= SLOT_0;
			endcase
		end
	end

endmodule

>>> rtl/m3ms_window.sv
module m3ms_window #(
	parameter int MAX_WINDOW = 48
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         acc,
	input  logic                         take,
	input  m3ms_pkg::sample_t            filtered,
	input  logic [m3ms_pkg::WLEN_W-1:0]  wlen,
	output m3ms_pkg::stage_t             s1
);
	import m3ms_pkg::*;

	localparam int PTR_W = $clog2(MAX_WINDOW);
	localparam int LEN_W = $clog2(MAX_WINDOW + 1);
	localparam int CW0   = (LEN_W > WLEN_W) ? LEN_W : WLEN_W;
	localparam int CW    = (CW0 > PTR_W + 1) ? CW0 : PTR_W + 1;

	sample_t              mem_q [MAX_WINDOW];
	logic [MAX_WINDOW-1:0] vld_q;
	logic [PTR_W-1:0]     ptr_q;
	logic                 ready_q;

	logic                 valid_s1;
	sample_t              filt_s1;
	sample_t              rdata_s1;
	logic                 rvld_s1;
	logic                 same_s1;
	logic                 ready_s1;

	logic [CW-1:0]        len_eff;
	logic [CW-1:0]        inc;
	logic                 wrap;
	logic [PTR_W-1:0]     nxt;
	logic                 ready_new;

	// effective length and next slot
	always_comb begin
		if (wlen == '0) begin
			len_eff = CW'(1);
		end else if (CW'(wlen) > CW'(MAX_WINDOW)) begin
			len_eff = CW'(MAX_WINDOW);
		end else begin
			len_eff = CW'(wlen);
		end
		inc       = CW'(ptr_q) + CW'(1);
		wrap      = (inc >= len_eff);
		nxt       = wrap ? '0 : inc[PTR_W-1:0];
		ready_new = ready_q || wrap;
	end

	// window memory: write current slot, read the slot after it
	always_ff @(posedge clk) begin
		if (acc) begin
			mem_q[ptr_q] <= filtered;
			rdata_s1     <= mem_q[nxt];
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (acc) begin
			filt_s1  <= filtered;
			rvld_s1  <= vld_q[nxt];
			same_s1  <= (nxt == ptr_q);
			ready_s1 <= ready_new;
		end
	end

	// pointer, ready flag, entry valid bits and stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q    <= '0;
			ready_q  <= 1'b0;
			vld_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (acc) begin
				ptr_q        <= nxt;
				ready_q      <= ready_new;
				vld_q[ptr_q] <= 1'b1;
			end
			if (acc) begin
				valid_s1 <= 1'b1;
			end else if (take) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	// forward the own write when the slot read is the one just written
	always_comb begin
		s1.valid    = valid_s1;
		s1.filtered = filt_s1;
		s1.ready    = ready_s1;
		if (same_s1) begin
			s1.sub = filt_s1;
		end else if (rvld_s1) begin
			s1.sub = rdata_s1;
		end else begin
			s1.sub = '0;
		end
	end

endmodule

>>> rtl/m3ms_sum.sv
module m3ms_sum (
	input  logic                       clk,
	input  logic                       arst_n,
	input  m3ms_pkg::stage_t           s1,
	input  logic                       m_axis_tready,
	output logic                       take,
	output logic                       m_axis_tvalid,
	output logic [55:0]                m_axis_tdata,
	output logic                       m_axis_tuser
);
	import m3ms_pkg::*;

	sum_t    sum_q;
	sum_t    sum_new;
	logic    out_valid_q;
	sample_t out_filt_q;
	sum_t    out_sum_q;
	logic    out_ready_q;

	assign take    = s1.valid && (!out_valid_q || m_axis_tready);
	assign sum_new = sum_q + SUM_W'(s1.filtered) - SUM_W'(s1.sub);

	// running sum and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (take) begin
			sum_q       <= sum_new;
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output payload register
	always_ff @(posedge clk) begin
		if (take) begin
			out_filt_q  <= s1.filtered;
			out_sum_q   <= sum_new;
			out_ready_q <= s1.ready;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {4'b0, out_sum_q, out_filt_q};
	assign m_axis_tuser  = out_ready_q;

endmodule

>>> rtl/median3_moving_sum_filter.sv
// Median-of-three then moving-sum filter for pressure samples. One sample is
// taken per clock unless the output stalls, and one result leaves per
// sample; it is registered in the window stage and in the output register before
// it is offered. The rate of one sample per cycle is set by the read-modify-write
// of the running sum and the window memory, which writes the current slot and
// reads the following slot in the same cycle. The window memory needs no
// clearing pass: per-slot valid bits, cleared at reset, make an unwritten slot
// read as zero. window_length may be written only while no sample is in flight.
module median3_moving_sum_filter #(
	parameter int MAX_WINDOW = 48
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [23:0]                 s_axis_tdata,  // [19:0] pressure_sample
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	output logic [55:0]                 m_axis_tdata,  // [19:0] filtered_sample, [51:20] pressure_sum
	output logic                        m_axis_tuser,  // [0] window_ready
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [m3ms_pkg::WLEN_W-1:0] cfg_data       // window_length
);
	import m3ms_pkg::*;

	logic [WLEN_W-1:0] wlen_q;
	logic              acc;
	logic              take;
	sample_t           filtered;
	stage_t            s1;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = !s1.valid || take;
	assign acc           = s_axis_tvalid && s_axis_tready;

	// window length register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlen_q <= WLEN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			wlen_q <= cfg_data;
		end
	end

	m3ms_median u_median (
		.clk      (clk),
		.arst_n   (arst_n),
		.acc      (acc),
		.sample   (s_axis_tdata[SAMPLE_W-1:0]),
		.filtered (filtered)
	);

	m3ms_window #(
		.MAX_WINDOW (MAX_WINDOW)
	) u_window (
		.clk      (clk),
		.arst_n   (arst_n),
		.acc      (acc),
		.take     (take),
		.filtered (filtered),
		.wlen     (wlen_q),
		.s1       (s1)
	);

	m3ms_sum u_sum (
		.clk           (clk),
		.arst_n        (arst_n),
		.s1            (s1),
		.m_axis_tready (m_axis_tready),
		.take          (take),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule

>>> rtl/m3ms_checker.sv
module m3ms_port_checker (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	input logic s_axis_tready,
	input logic m_axis_tvalid,
	input logic m_axis_tready,
	input logic m_axis_tuser
);

	logic [2:0] inflight_q;
	logic       seen_ready_q;
	logic       in_xfer;
	logic       out_xfer;

	assign in_xfer  = s_axis_tvalid && s_axis_tready;
	assign out_xfer = m_axis_tvalid && m_axis_tready;

	// samples taken but not yet delivered, and ready flag history
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q   <= '0;
			seen_ready_q <= 1'b0;
		end else begin
			inflight_q <= inflight_q + 3'(in_xfer) - 3'(out_xfer);
			if (out_xfer && m_axis_tuser) begin
				seen_ready_q <= 1'b1;
			end
		end
	end

	// a held result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result dropped while stalled");

	// no result without a sample behind it
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> inflight_q != 3'd0)
		else $error("result without a pending sample");

	// at most two samples in flight
	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= 3'd2)
		else $error("too many samples in flight");

	// the ready flag never falls once shown
	a_ready_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer && seen_ready_q |-> m_axis_tuser)
		else $error("window ready flag fell");

endmodule

bind median3_moving_sum_filter m3ms_port_checker u_m3ms_checker (.*);

>>> sim/m3ms_checker.sv
// watches the sample, result and window-length channels, predicts each
// result and compares it with what the filter returns
module m3ms_checker #(
	parameter int MAX_WINDOW = 48
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	input  logic                        s_axis_tready,
	input  logic [23:0]                 s_axis_tdata,  // [19:0] pressure_sample
	input  logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	input  logic [55:0]                 m_axis_tdata,  // [19:0] filtered_sample, [51:20] pressure_sum
	input  logic                        m_axis_tuser,  // [0] window_ready
	input  logic                        cfg_valid,
	input  logic                        cfg_ready,
	input  logic [m3ms_pkg::WLEN_W-1:0] cfg_data,      // window_length
	output int                          fail_count,
	output int                          pending
);
	import m3ms_pkg::*;

	typedef struct packed {
		sample_t filtered;
		sum_t    total;
		logic    rdy;
	} filter_result_t;

	// predicted filter state
	logic [WLEN_W-1:0] win_len;
	sample_t           med_ring [TAPS];
	int                med_ptr;
	logic              med_full;
	sample_t           win_mem [MAX_WINDOW];
	int                win_ptr;
	logic              win_ready;
	sum_t              acc;

	filter_result_t    expected_results [$];
	int                fails;

	assign fail_count = fails;
	assign pending    = expected_results.size();

	// middle value as max(min(a,b), min(max(a,b),c))
	function automatic sample_t middle_of(sample_t a, sample_t b, sample_t c);
		sample_t mn;
		sample_t mx;
		sample_t cap;
		mn  = (a < b) ? a : b;
		mx  = (a < b) ? b : a;
		cap = (mx < c) ? mx : c;
		return (mn > cap) ? mn : cap;
	endfunction

	task automatic clear_filter();
		win_len   = WLEN_RESET;
		med_ptr   = 0;
		med_full  = 1'b0;
		win_ptr   = 0;
		win_ready = 1'b0;
		acc       = '0;
		for (int i = 0; i < TAPS; i++) med_ring[i] = '0;
		for (int i = 0; i < MAX_WINDOW; i++) win_mem[i] = '0;
	endtask

	// advance the predicted state by one sample and queue its result
	task automatic predict_sample(input sample_t raw);
		int             span;
		int             cur;
		int             nxt;
		int             slot;
		int             slot_nxt;
		sample_t        filt;
		filter_result_t res;
		span = int'(win_len);
		if (span < 1) span = 1;
		if (span > MAX_WINDOW) span = MAX_WINDOW;
		cur = (win_ptr < MAX_WINDOW) ? win_ptr : 0;
		nxt = cur + 1;
		if (nxt >= span) begin
			nxt       = 0;
			win_ready = 1'b1;
		end
		// median ring, raw sample until it has filled once
		slot     = (med_ptr < TAPS) ? med_ptr : 0;
		slot_nxt = slot + 1;
		if (slot_nxt >= TAPS) begin
			slot_nxt = 0;
			med_full = 1'b1;
		end
		med_ring[slot] = raw;
		med_ptr        = slot_nxt;
		filt = med_full ? middle_of(med_ring[0], med_ring[1], med_ring[2]) : raw;
		// window write, then add new and drop the following slot
		win_mem[cur] = filt;
		acc          = acc + sum_t'(filt);
		acc          = acc - sum_t'(win_mem[nxt]);
		win_ptr      = nxt;
		res.filtered = filt;
		res.total    = acc;
		res.rdy      = win_ready;
		expected_results.push_back(res);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_filter();
			expected_results.delete();
			fails = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				win_len = cfg_data;
			end
			if (s_axis_tvalid && s_axis_tready) begin
				predict_sample(s_axis_tdata[SAMPLE_W-1:0]);
			end
			// compare each result transfer with the oldest prediction
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_results.size() == 0) begin
					$error("result transfer with no prediction pending: tdata %h tuser %b",
						m_axis_tdata, m_axis_tuser);
					fails++;
				end else begin
					filter_result_t want;
					want = expected_results.pop_front();
					if (m_axis_tdata[19:0] !== want.filtered) begin
						$error("filtered_sample expected %0d actual %0d",
							want.filtered, m_axis_tdata[19:0]);
						fails++;
					end
					if (m_axis_tdata[51:20] !== want.total) begin
						$error("pressure_sum expected %0d actual %0d",
							want.total, m_axis_tdata[51:20]);
						fails++;
					end
					if (m_axis_tuser !== want.rdy) begin
						$error("window_ready expected %0d actual %0d",
							want.rdy, m_axis_tuser);
						fails++;
					end
				end
			end
		end
	end

endmodule

>>> sim/testbench.sv
module testbench;
	import m3ms_pkg::*;

	typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

	localparam int PHASES        = 12;
	localparam int PHASE_ITEMS   = 130;
	localparam int SQUEEZE_PHASE = 4;
	localparam int SQUEEZE_LEN   = 300;
	localparam int SETTLE_CYCLES = 4;

	logic              clk           = 1'b0;
	logic              arst_n        = 1'b0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [23:0]       s_axis_tdata  = '0;
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [55:0]       m_axis_tdata;
	logic              m_axis_tuser;
	logic              cfg_valid     = 1'b0;
	logic              cfg_ready;
	logic [WLEN_W-1:0] cfg_data      = '0;

	int   send_idle_pct = 0;
	int   recv_stall_pct = 0;
	logic squeeze_req   = 1'b0;
	logic hold_on       = 1'b0;
	int   fail_count;
	int   pending;

	median3_moving_sum_filter #(.MAX_WINDOW(48)) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	m3ms_checker #(.MAX_WINDOW(48)) u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.fail_count    (fail_count),
		.pending       (pending)
	);

	// clock, period 2
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// receiver back-pressure
	always @(posedge clk) begin
		m_axis_tready <= !hold_on && ($urandom_range(0, 99) >= recv_stall_pct);
	end

	// one long receiver hold-off so the filter fills and stalls its input
	initial begin
		wait (squeeze_req);
		@(posedge clk);
		hold_on <= 1'b1;
		repeat (SQUEEZE_LEN) @(posedge clk);
		hold_on <= 1'b0;
	end

	// run timeout
	initial begin
		#400000;
		$display("RESULT: ERROR");
		$finish;
	end

	task automatic set_idle(input idle_mode_t mode);
		case (mode)
			IDLE_NONE: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			IDLE_SEND: begin send_idle_pct = 59; recv_stall_pct = 0;  end
			IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 59; end
			default:   begin send_idle_pct = 8;  recv_stall_pct = 8;  end
		endcase
	endtask

	// offer one sample and hold it until the transfer
	task automatic send_sample(input sample_t smp);
		while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {4'b0, smp};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	// wait until every predicted result has come back, then let the design settle
	task automatic drain();
		do @(negedge clk); while (pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_length(input logic [WLEN_W-1:0] len);
		drain();
		cfg_valid <= 1'b1;
		cfg_data  <= len;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_run(input sample_t vals [$]);
		foreach (vals[i]) send_sample(vals[i]);
		s_axis_tvalid <= 1'b0;
	endtask

	// mix of full-range, near-top, near-zero and mid-scale samples
	function automatic sample_t pick_sample();
		case ($urandom_range(0, 3))
			0:       return sample_t'($urandom);
			1:       return sample_t'(20'hFFFFF - $urandom_range(0, 63));
			2:       return sample_t'($urandom_range(0, 63));
			default: return sample_t'(20'h80000 + $urandom_range(0, 4095) - 2048);
		endcase
	endfunction

	function automatic logic [WLEN_W-1:0] phase_length(input int ph);
		case (ph)
			0:       return 6'd48;
			1:       return 6'd2;
			2:       return 6'd63;
			3:       return 6'd0;
			4:       return 6'd37;
			5:       return 6'd1;
			default: return WLEN_W'($urandom_range(0, 63));
		endcase
	endfunction

	initial begin
		sample_t q [$];
		idle_mode_t mode;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset length, extremes, median ordering, equal samples
		set_idle(IDLE_NONE);
		q = '{20'h00000, 20'hFFFFF, 20'h00001, 20'hFFFFF, 20'h00000, 20'h7FFFF,
			20'h80000, 20'h80000, 20'h80000, 20'h00003, 20'h00002, 20'h00001};
		send_run(q);
		// length one: sum unchanged, ready at once
		write_length(6'd1);
		q = '{20'hFFFFF, 20'h12345, 20'h00000};
		send_run(q);
		// length zero acts as one
		write_length(6'd0);
		q = '{20'hABCDE, 20'hFFFFF, 20'h54321};
		send_run(q);
		// length above the window size acts as the maximum
		write_length(6'd63);
		q = '{20'hFFFFF, 20'hFFFFF, 20'h00000, 20'hFFFFF};
		send_run(q);

		// random phases, each with its own length and idle pattern
		for (int ph = 0; ph < PHASES; ph++) begin
			write_length(phase_length(ph));
			mode = idle_mode_t'(ph % 4);
			set_idle(mode);
			if (ph == SQUEEZE_PHASE) begin
				set_idle(IDLE_NONE);
				squeeze_req <= 1'b1;
			end
			for (int n = 0; n < PHASE_ITEMS; n++) send_sample(pick_sample());
			s_axis_tvalid <= 1'b0;
		end

		set_idle(IDLE_NONE);
		drain();
		repeat (8) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
